// ===== rtl/jets_pkg.sv =====
// Shared types, constants and the exponential lookup table for the Julia escape-time engine.
// Used by jets_cfg, jets_ctrl, jets_dp, julia_escape_time_smooth and tb; depends on nothing else.
// All values are fixed point: z is signed Q4.28, |z|^2 is unsigned Q8.56, the sum is Q10.16.
package jets_pkg;

    // Image geometry and table size.
    localparam int IMG_WIDTH       = 1024;
    localparam int IMG_HEIGHT      = 1024;
    localparam int EXP_TABLE_DEPTH = 256;

    // Field widths.
    localparam int PIX_W   = 10;
    localparam int ITER_W  = 10;
    localparam int SUM_W   = 26;
    localparam int Z_W     = 32;
    localparam int STEP_W  = 31;
    localparam int PROD_W  = 2 * Z_W;
    localparam int OFF_W   = 14;
    localparam int IDX_W   = 3;

    // Exponential table geometry.
    localparam int EXP_IDX_W = $clog2(EXP_TABLE_DEPTH);
    localparam int EXP_VAL_W = 17;
    localparam int SCL_W     = 32 + EXP_IDX_W + 1;

    // Thresholds on |z|^2 in Q8.56 and the saturation limit of the sum.
    localparam logic [PROD_W-1:0] ESC_LIMIT = 64'h0400_0000_0000_0000;
    localparam logic [PROD_W-1:0] EXP_LIMIT = 64'h0800_0000_0000_0000;
    localparam logic [SUM_W-1:0]  SUM_MAX   = 26'h3FF_FFFF;

    // Register indexes of the configuration port.
    typedef enum logic [IDX_W-1:0] {
        CFG_CONST_RE = 3'd0,
        CFG_CONST_IM = 3'd1,
        CFG_STEP_RE  = 3'd2,
        CFG_STEP_IM  = 3'd3,
        CFG_PAN_RE   = 3'd4,
        CFG_PAN_IM   = 3'd5,
        CFG_MAX_ITER = 3'd6
    } t_cfg_idx;

    // Configuration register file contents.
    typedef struct packed {
        logic signed [Z_W-1:0] const_re;
        logic signed [Z_W-1:0] const_im;
        logic [STEP_W-1:0]     step_re;
        logic [STEP_W-1:0]     step_im;
        logic signed [Z_W-1:0] pan_re;
        logic signed [Z_W-1:0] pan_im;
        logic [ITER_W-1:0]     max_iter;
    } t_cfg;

    // Reset values of the configuration registers.
    localparam logic signed [Z_W-1:0] RST_CONST_RE = -32'sd1879048192;
    localparam logic signed [Z_W-1:0] RST_CONST_IM = 32'sd73819750;
    localparam logic [STEP_W-1:0]     RST_STEP_RE  = 31'd786432;
    localparam logic [STEP_W-1:0]     RST_STEP_IM  = 31'd524288;
    localparam logic signed [Z_W-1:0] RST_PAN_RE   = 32'sd0;
    localparam logic signed [Z_W-1:0] RST_PAN_IM   = 32'sd0;
    localparam logic [ITER_W-1:0]     RST_MAX_ITER = 10'd256;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_load;
        logic mul_offs;
        logic z_load;
        logic upd;
        logic acc_start;
        logic acc;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_start;
        logic last;
    } t_dp_status;

    typedef logic [EXP_VAL_W-1:0] t_exp_tbl [EXP_TABLE_DEPTH];

    // Builds round(2^16 * e^-(8i/D)): a Taylor series of e^-u through u^12 in Q0.32,
    // squared three times, then rounded half up to Q0.16. Evaluated at elaboration.
    function automatic t_exp_tbl exp_tbl_build();
        t_exp_tbl           tbl;
        logic [127:0]        u;
        logic [127:0]        term;
        logic [127:0]        s;
        logic signed [127:0] sum;
        int                  i;
        int                  k;
        for (i = 0; i < EXP_TABLE_DEPTH; i++) begin
            if (i == 0) begin
                tbl[i] = 17'd65536;
            end else begin
                u    = (128'(i) << 32) / EXP_TABLE_DEPTH;
                sum  = 128'sd1 << 32;
                term = 128'd1 << 32;
                for (k = 1; k <= 12; k++) begin
                    term = (term * u) >> 32;
                    case (k)
                        1:       term = term / 1;
                        2:       term = term / 2;
                        3:       term = term / 3;
                        4:       term = term / 4;
                        5:       term = term / 5;
                        6:       term = term / 6;
                        7:       term = term / 7;
                        8:       term = term / 8;
                        9:       term = term / 9;
                        10:      term = term / 10;
                        11:      term = term / 11;
                        default: term = term / 12;
                    endcase
                    if ((k % 2) == 1) begin
                        sum = sum - $signed(term);
                    end else begin
                        sum = sum + $signed(term);
                    end
                end
                if (sum < 0) begin
                    sum = 128'sd0;
                end
                s = sum;
                if (s > 128'hFFFF_FFFF) begin
                    s = 128'hFFFF_FFFF;
                end
                for (k = 0; k < 3; k++) begin
                    s = (s * s) >> 32;
                end
                tbl[i] = EXP_VAL_W'((s + 128'd32768) >> 16);
            end
        end
        return tbl;
    endfunction

    localparam t_exp_tbl EXP_TBL = exp_tbl_build();

endpackage

// ===== rtl/jets_cfg.sv =====
// Configuration register file for the Julia escape-time engine.
// Depends on jets_pkg for the register indexes, reset values and the t_cfg struct.
module jets_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [jets_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [jets_pkg::Z_W-1:0]     i_cfg_data,
    output jets_pkg::t_cfg               o_cfg
);

    jets_pkg::t_cfg r_cfg;
    jets_pkg::t_cfg n_cfg;

    // Writes are always taken; an index beyond the list changes nothing.
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Decode the register index of a write request.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                jets_pkg::CFG_CONST_RE: n_cfg.const_re = i_cfg_data;
                jets_pkg::CFG_CONST_IM: n_cfg.const_im = i_cfg_data;
                jets_pkg::CFG_STEP_RE:  n_cfg.step_re  = i_cfg_data[jets_pkg::STEP_W-1:0];
                jets_pkg::CFG_STEP_IM:  n_cfg.step_im  = i_cfg_data[jets_pkg::STEP_W-1:0];
                jets_pkg::CFG_PAN_RE:   n_cfg.pan_re   = i_cfg_data;
                jets_pkg::CFG_PAN_IM:   n_cfg.pan_im   = i_cfg_data;
                jets_pkg::CFG_MAX_ITER: n_cfg.max_iter = i_cfg_data[jets_pkg::ITER_W-1:0];
                default:                n_cfg = r_cfg;
            endcase
        end
    end

    // Register file with its documented reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.const_re <= jets_pkg::RST_CONST_RE;
            r_cfg.const_im <= jets_pkg::RST_CONST_IM;
            r_cfg.step_re  <= jets_pkg::RST_STEP_RE;
            r_cfg.step_im  <= jets_pkg::RST_STEP_IM;
            r_cfg.pan_re   <= jets_pkg::RST_PAN_RE;
            r_cfg.pan_im   <= jets_pkg::RST_PAN_IM;
            r_cfg.max_iter <= jets_pkg::RST_MAX_ITER;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== rtl/jets_dp.sv =====
// Datapath of the Julia escape-time engine: three 32x32 multipliers, two of them shared, the z update,
// |z|^2, the exponential lookup with saturating sum, and the result register. Uses jets_pkg.
module jets_dp (
    input  logic                            i_clk,
    input  jets_pkg::t_cfg                  i_cfg,
    input  jets_pkg::t_dp_cmd               i_cmd,
    output jets_pkg::t_dp_status            o_status,
    input  logic [jets_pkg::PIX_W-1:0]      i_pixel_x,
    input  logic [jets_pkg::PIX_W-1:0]      i_pixel_y,
    output logic [jets_pkg::ITER_W-1:0]     o_iter_count,
    output logic                            o_escaped,
    output logic [jets_pkg::SUM_W-1:0]      o_smooth_sum
);

    localparam int PW = jets_pkg::PROD_W;
    localparam int ZW = jets_pkg::Z_W;
    localparam int OW = jets_pkg::OFF_W;
    localparam int HalfW = jets_pkg::IMG_WIDTH / 2;
    localparam int HalfH = jets_pkg::IMG_HEIGHT / 2;

    // Clamp a 66-bit signed value to the 32-bit signed range.
    function automatic logic signed [ZW-1:0] sat32(input logic signed [PW+1:0] v);
        logic signed [ZW-1:0] res;
        if (v[PW+1:ZW-1] == '0 || v[PW+1:ZW-1] == '1) begin
            res = v[ZW-1:0];
        end else if (v[PW+1]) begin
            res = {1'b1, {(ZW-1){1'b0}}};
        end else begin
            res = {1'b0, {(ZW-1){1'b1}}};
        end
        return res;
    endfunction

    logic [jets_pkg::PIX_W-1:0]       r_px;
    logic [jets_pkg::PIX_W-1:0]       r_py;
    logic signed [ZW-1:0]             r_zr;
    logic signed [ZW-1:0]             r_zi;
    logic signed [PW-1:0]             r_p0;
    logic signed [PW-1:0]             r_p1;
    logic signed [PW-1:0]             r_p2;
    logic [PW-1:0]                    r_mag;
    logic [jets_pkg::ITER_W-1:0]      r_iter;
    logic                             r_esc;
    logic [jets_pkg::SUM_W-1:0]       r_sum;

    logic signed [OW-1:0]             w_px_off;
    logic signed [OW-1:0]             w_py_off;
    logic signed [ZW-1:0]             w_a0;
    logic signed [ZW-1:0]             w_b0;
    logic signed [ZW-1:0]             w_a1;
    logic signed [ZW-1:0]             w_b1;
    logic signed [ZW-1:0]             w_a2;
    logic signed [ZW-1:0]             w_b2;
    logic signed [PW-1:0]             w_p0;
    logic signed [PW-1:0]             w_p1;
    logic signed [PW-1:0]             w_p2;
    logic signed [PW:0]               w_diff;
    logic signed [PW:0]               w_dsh;
    logic signed [PW-1:0]             w_ish;
    logic signed [PW+1:0]             w_nr;
    logic signed [PW+1:0]             w_ni;
    logic signed [PW+1:0]             w_zr0;
    logic signed [PW+1:0]             w_zi0;
    logic                             w_esc;
    logic [jets_pkg::SCL_W-1:0]       w_scaled;
    logic [jets_pkg::EXP_IDX_W:0]     w_idx_full;
    logic [jets_pkg::EXP_IDX_W-1:0]   w_idx;
    logic [jets_pkg::EXP_VAL_W-1:0]   w_term;
    logic [jets_pkg::SUM_W:0]         w_sum_ext;
    logic [jets_pkg::SUM_W-1:0]       w_sum_acc;
    logic [jets_pkg::SUM_W-1:0]       w_term_ext;
    logic [jets_pkg::ITER_W:0]        w_iter_nx;

    // Pixel offsets from the screen center.
    assign w_px_off = $signed({{(OW-jets_pkg::PIX_W){1'b0}}, r_px}) - OW'(HalfW);
    assign w_py_off = $signed({{(OW-jets_pkg::PIX_W){1'b0}}, r_py}) - OW'(HalfH);

    // Operand selection: offset times step for the start point, else the squares and cross term.
    always_comb begin
        if (i_cmd.mul_offs) begin
            w_a0 = {{(ZW-OW){w_px_off[OW-1]}}, w_px_off};
            w_b0 = {1'b0, i_cfg.step_re};
            w_a1 = {{(ZW-OW){w_py_off[OW-1]}}, w_py_off};
            w_b1 = {1'b0, i_cfg.step_im};
        end else begin
            w_a0 = r_zr;
            w_b0 = r_zr;
            w_a1 = r_zi;
            w_b1 = r_zi;
        end
        w_a2 = r_zr;
        w_b2 = r_zi;
    end

    assign w_p0 = w_a0 * w_b0;
    assign w_p1 = w_a1 * w_b1;
    assign w_p2 = w_a2 * w_b2;

    // Next iterate from the registered products, with floor shifts and saturation.
    assign w_diff = $signed({r_p0[PW-1], r_p0}) - $signed({r_p1[PW-1], r_p1});
    assign w_dsh  = w_diff >>> 28;
    assign w_ish  = r_p2 >>> 27;
    assign w_nr   = $signed({w_dsh[PW], w_dsh})
                  + $signed({{(PW+2-ZW){i_cfg.const_re[ZW-1]}}, i_cfg.const_re});
    assign w_ni   = $signed({{2{w_ish[PW-1]}}, w_ish})
                  + $signed({{(PW+2-ZW){i_cfg.const_im[ZW-1]}}, i_cfg.const_im});

    // Start point: offset times step plus the pan.
    assign w_zr0 = $signed({{2{r_p0[PW-1]}}, r_p0})
                 + $signed({{(PW+2-ZW){i_cfg.pan_re[ZW-1]}}, i_cfg.pan_re});
    assign w_zi0 = $signed({{2{r_p1[PW-1]}}, r_p1})
                 + $signed({{(PW+2-ZW){i_cfg.pan_im[ZW-1]}}, i_cfg.pan_im});

    // Exponential term of the registered |z|^2: zero at or beyond 8.
    assign w_scaled   = {{(jets_pkg::SCL_W-32){1'b0}}, r_mag[58:27]}
                      * jets_pkg::SCL_W'(jets_pkg::EXP_TABLE_DEPTH);
    assign w_idx_full = w_scaled[jets_pkg::SCL_W-1:32];
    assign w_idx      = (w_idx_full >= (jets_pkg::EXP_IDX_W+1)'(jets_pkg::EXP_TABLE_DEPTH))
                      ? jets_pkg::EXP_IDX_W'(jets_pkg::EXP_TABLE_DEPTH - 1)
                      : w_idx_full[jets_pkg::EXP_IDX_W-1:0];
    assign w_term     = (r_mag >= jets_pkg::EXP_LIMIT) ? '0 : jets_pkg::EXP_TBL[w_idx];
    assign w_term_ext = {{(jets_pkg::SUM_W-jets_pkg::EXP_VAL_W){1'b0}}, w_term};

    // Saturating accumulation and escape test.
    assign w_sum_ext = {1'b0, r_sum} + {1'b0, w_term_ext};
    assign w_sum_acc = (w_sum_ext > {1'b0, jets_pkg::SUM_MAX})
                     ? jets_pkg::SUM_MAX : w_sum_ext[jets_pkg::SUM_W-1:0];
    assign w_esc     = r_mag > jets_pkg::ESC_LIMIT;
    assign w_iter_nx = {1'b0, r_iter} + 1'b1;

    assign o_status.last_start = (i_cfg.max_iter == '0);
    assign o_status.last       = w_esc || (w_iter_nx == {1'b0, i_cfg.max_iter});

    // Products are registered every cycle before any further arithmetic.
    always_ff @(posedge i_clk) begin
        r_p0 <= w_p0;
        r_p1 <= w_p1;
        r_p2 <= w_p2;
    end

    // Pixel capture, z recurrence and |z|^2.
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_px <= i_pixel_x;
            r_py <= i_pixel_y;
        end
        if (i_cmd.z_load) begin
            r_zr <= sat32(w_zr0);
            r_zi <= sat32(w_zi0);
        end else if (i_cmd.upd) begin
            r_zr <= sat32(w_nr);
            r_zi <= sat32(w_ni);
        end
        if (i_cmd.upd) begin
            r_mag <= r_p0 + r_p1;
        end
    end

    // Running sum, iteration count and escape flag.
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_start) begin
            r_sum  <= w_term_ext;
            r_iter <= '0;
            r_esc  <= 1'b0;
        end else if (i_cmd.acc) begin
            r_sum  <= w_sum_acc;
            r_iter <= w_iter_nx[jets_pkg::ITER_W-1:0];
            r_esc  <= w_esc;
        end
    end

    // Result register toward the output channel.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_iter_count <= r_iter;
            o_escaped    <= r_esc;
            o_smooth_sum <= r_sum;
        end
    end

endmodule

// ===== rtl/jets_ctrl.sv =====
// Controller of the Julia escape-time engine: sequences start point, iterations and result.
// Drives jets_dp through t_dp_cmd and reads t_dp_status; uses jets_pkg.
module jets_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    input  jets_pkg::t_dp_status  i_status,
    output jets_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_OFFS,
        S_LOAD,
        S_MUL0,
        S_UPD0,
        S_ACC0,
        S_UPD,
        S_ACC,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    // The result register can take a new result when empty or being emptied.
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and datapath commands.
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.in_load = 1'b1;
                    n_state       = S_OFFS;
                end
            end
            S_OFFS: begin
                o_cmd.mul_offs = 1'b1;
                n_state        = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.z_load = 1'b1;
                n_state      = S_MUL0;
            end
            S_MUL0: begin
                n_state = S_UPD0;
            end
            S_UPD0: begin
                o_cmd.upd = 1'b1;
                n_state   = S_ACC0;
            end
            S_ACC0: begin
                o_cmd.acc_start = 1'b1;
                n_state         = i_status.last_start ? S_FIN : S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_status.last ? S_FIN : S_UPD;
            end
            S_FIN: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and output-valid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/julia_escape_time_smooth.sv =====
// Julia-set escape-time pixel engine with a smooth exponential sum.
// Input channel: i_in_valid / o_in_stall with i_pixel_x, i_pixel_y; a request is taken
// at an edge where valid is high and stall is low. Output channel: o_out_valid /
// i_out_stall with o_iter_count, o_escaped, o_smooth_sum, held while stalled.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index, i_cfg_data; o_cfg_ready is
// always high. The user must make writes only while no pixel is in flight: the block
// does not enforce it. One pixel is worked on at a time; a new request is taken only
// once the last result has moved into the output register. Each iteration registers
// the products of z out of the three 32x32 multipliers, two of them shared, then forms
// the next z and |z|^2 from them.
// The result sits in an output register, so a stalled receiver holds back only the
// next result, not the following request; a finished pixel waits for that register.
// Reset (synchronous, active low) returns the controller to idle, empties the output
// register and restores every configuration register to its default.
module julia_escape_time_smooth (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [jets_pkg::PIX_W-1:0]     i_pixel_x,
    input  logic [jets_pkg::PIX_W-1:0]     i_pixel_y,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [jets_pkg::ITER_W-1:0]    o_iter_count,
    output logic                           o_escaped,
    output logic [jets_pkg::SUM_W-1:0]     o_smooth_sum,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [jets_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [jets_pkg::Z_W-1:0]       i_cfg_data
);

    jets_pkg::t_cfg       w_cfg;
    jets_pkg::t_dp_cmd    w_cmd;
    jets_pkg::t_dp_status w_status;

    // Configuration registers.
    jets_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Sequencer.
    jets_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Arithmetic and result register.
    jets_dp u_dp (
        .i_clk        (i_clk),
        .i_cfg        (w_cfg),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .o_iter_count (o_iter_count),
        .o_escaped    (o_escaped),
        .o_smooth_sum (o_smooth_sum)
    );

`ifndef ASSERT_OFF
    // A pending result never reports more iterations than the limit.
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_iter_count <= w_cfg.max_iter))
        else $error("iteration count above limit");

    // A point that did not escape ran exactly the full limit.
    a_no_escape_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_escaped) |-> (o_iter_count == w_cfg.max_iter))
        else $error("non-escaped result ended early");

    // An escape needs at least one iterate.
    a_escape_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_escaped) |-> (o_iter_count != '0))
        else $error("escape reported with zero iterations");

    // After a request is taken, the block is busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second request taken while busy");
`endif

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the Julia escape-time engine with its smooth exponential sum.
// Runs a directed table and then random phases against a predictor of the pixel iteration.
// Depends on jets_pkg for port widths, image geometry and register indexes.
module tb;

    typedef longint unsigned t_u64;

    // Own thresholds on |z|^2 (Q8.56) and the cap of the sum (Q10.16).
    localparam t_u64             MAG_ESC     = 64'd4 << 56;
    localparam t_u64             MAG_EXP_CUT = 64'd8 << 56;
    localparam int unsigned      SUM_CAP     = 32'd67108863;
    localparam logic [jets_pkg::IDX_W-1:0] CFG_NONE_IDX = 3'd7;
    localparam int               CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [jets_pkg::ITER_W-1:0] iters;
        logic                        escaped;
        logic [jets_pkg::SUM_W-1:0]  smooth;
    } t_pixel_res;

    typedef enum logic {
        R_PIX,
        R_CFG
    } t_dir_kind;

    typedef struct packed {
        t_dir_kind                   kind;
        logic [jets_pkg::IDX_W-1:0]  idx;
        logic [jets_pkg::Z_W-1:0]    data;
        logic [jets_pkg::PIX_W-1:0]  px;
        logic [jets_pkg::PIX_W-1:0]  py;
        logic                        typed;
        logic [jets_pkg::ITER_W-1:0] iters;
        logic                        escaped;
        logic [jets_pkg::SUM_W-1:0]  smooth;
    } t_dir_row;

    localparam int DIR_ROWS = 40;

    // Directed stimulus: register writes and pixels, with results typed in where obvious.
    localparam t_dir_row DIR_TBL [DIR_ROWS] = '{
        // Reset settings: the centre escapes on the first iterate, which lies beyond the table.
        '{R_PIX, CFG_NONE_IDX, 32'd0, 10'd512, 10'd512, 1'b1, 10'd1, 1'b1, 26'd65536},
        '{R_PIX, CFG_NONE_IDX, 32'd0, 10'd0, 10'd0, 1'b0, 10'd0, 1'b0, 26'd0},
        '{R_PIX, CFG_NONE_IDX, 32'd0, 10'd1023, 10'd1023, 1'b0, 10'd0, 1'b0, 26'd0},
        // A zero constant keeps the centre at the origin.
        '{R_CFG, jets_pkg::CFG_CONST_RE, 32'd0, 10'd0, 10'd0, 1'b0, 10'd0, 1'b0, 26'd0},
        '{R_CFG, jets_pkg::CFG_CONST_IM, 32'd0, 10'd0, 10'd0, 1'b0, 10'd0, 1'b0, 26'd0},
        '{R_CFG, jets_pkg::CFG_MAX_ITER, 32'd1, 10'd0, 10'd0, 1'b0, 10'd0, 1'b0, 26'd0},
        '{R_PIX, CFG_NONE_IDX, 32'd0, 10'd512, 10'd512, 1'b1, 10'd1, 1'b0, 26'd131072},
        // Zero limit, written with high bits that the register drops.
        '{R_CFG, jets_pkg::CFG_MAX_ITER, 32'hFFFF_FC00, 10'd0, 10'd0, 1'b0, 10'd0, 1'b0, 26'd0},
        '{R_PIX, CFG_NONE_IDX, 32'd0, 10'd512, 10'd512, 1'b1, 10'd0, 1'b0, 26'd65536},
        // Largest limit at the origin saturates the sum.
        '{R_CFG, jets_pkg::CFG_MAX_ITER, 32'd1023, 10'd0, 10'd0, 1'b0, 10'd0, 1'b0, 26'd0},
        '{R_PIX, CFG_NONE_IDX, 32'd0, 10'd512, 10'd512, 1'b1, 10'd1023, 1'b0, 26'h3FF_FFFF},
        // A write beyond the register list must leave the limit of eight alone.
        '{R_CFG, jets_pkg::CFG_MAX_ITER, 32'hFFFF_FC08, 10'd0, 10'd0, 1'b0, 10'd0, 1'b0, 26'd0},
        '{R_CFG, CFG_NONE_IDX, 32'hFFFF_FFFF, 10'd0, 10'd0, 1'b0, 10'd0, 1'b0, 26'd0},
        '{R_PIX, CFG_NONE_IDX, 32'd0, 10'd512, 10'd512, 1'b1, 10'd8, 1'b0, 26'd589824},
        // Start at 1.5: escapes early, then exactly on the last allowed iteration.
        '{R_CFG, jets_pkg::CFG_PAN_RE, 32'd402653184, 10'd0, 10'd0, 1'b0, 10'd0, 1'b0, 26'd0},
        '{R_PIX, CFG_NONE_IDX, 32'd0, 10'd512, 10'd512, 1'b0, 10'd0, 1'b0, 26'd0},
        '{R_CFG, jets_pkg::CFG_MAX_ITER, 32'd1, 10'd0, 10'd0, 1'b0, 10'd0, 1'b0, 26'd0},
        '{R_PIX, CFG_NONE_IDX, 32'd0, 10'd512, 10'd512, 1'b0, 10'd0, 1'b0, 26'd0},
        // Start beyond the escape radius is not tested; c at its most negative pulls it back.
        '{R_CFG, jets_pkg::CFG_PAN_RE, 32'd771751936, 10'd0, 10'd0, 1'b0, 10'd0, 1'b0, 26'd0},
        '{R_CFG, jets_pkg::CFG_CONST_RE, 32'h8000_0000, 10'd0, 10'd0, 1'b0, 10'd0, 1'b0, 26'd0},
        '{R_PIX, CFG_NONE_IDX, 32'd0, 10'd512, 10'd512, 1'b0, 10'd0, 1'b0, 26'd0},
        // Extreme steps, pans and constant: the start point saturates at the corners.
        '{R_CFG, jets_pkg::CFG_STEP_RE, 32'hFFFF_FFFF, 10'd0, 10'd0, 1'b0, 10'd0, 1'b0, 26'd0},
        '{R_CFG, jets_pkg::CFG_STEP_IM, 32'h7FFF_FFFF, 10'd0, 10'd0, 1'b0, 10'd0, 1'b0, 26'd0},
        '{R_CFG, jets_pkg::CFG_PAN_RE, 32'h7FFF_FFFF, 10'd0, 10'd0, 1'b0, 10'd0, 1'b0, 26'd0},
        '{R_CFG, jets_pkg::CFG_PAN_IM, 32'h8000_0000, 10'd0, 10'd0, 1'b0, 10'd0, 1'b0, 26'd0},
        '{R_CFG, jets_pkg::CFG_CONST_IM, 32'h7FFF_FFFF, 10'd0, 10'd0, 1'b0, 10'd0, 1'b0, 26'd0},
        '{R_CFG, jets_pkg::CFG_MAX_ITER, 32'd4, 10'd0, 10'd0, 1'b0, 10'd0, 1'b0, 26'd0},
        '{R_PIX, CFG_NONE_IDX, 32'd0, 10'd0, 10'd0, 1'b0, 10'd0, 1'b0, 26'd0},
        '{R_PIX, CFG_NONE_IDX, 32'd0, 10'd1023, 10'd1023, 1'b0, 10'd0, 1'b0, 26'd0},
        '{R_PIX, CFG_NONE_IDX, 32'd0, 10'd0, 10'd1023, 1'b0, 10'd0, 1'b0, 26'd0},
        '{R_PIX, CFG_NONE_IDX, 32'd0, 10'd1023, 10'd0, 1'b0, 10'd0, 1'b0, 26'd0},
        '{R_PIX, CFG_NONE_IDX, 32'd0, 10'd512, 10'd512, 1'b0, 10'd0, 1'b0, 26'd0},
        // A classic constant near the set boundary with a normal view.
        '{R_CFG, jets_pkg::CFG_CONST_RE, 32'hF333_3333, 10'd0, 10'd0, 1'b0, 10'd0, 1'b0, 26'd0},
        '{R_CFG, jets_pkg::CFG_CONST_IM, 32'd41875931, 10'd0, 10'd0, 1'b0, 10'd0, 1'b0, 26'd0},
        '{R_CFG, jets_pkg::CFG_STEP_RE, 32'd786432, 10'd0, 10'd0, 1'b0, 10'd0, 1'b0, 26'd0},
        '{R_CFG, jets_pkg::CFG_STEP_IM, 32'd524288, 10'd0, 10'd0, 1'b0, 10'd0, 1'b0, 26'd0},
        '{R_CFG, jets_pkg::CFG_PAN_RE, 32'd0, 10'd0, 10'd0, 1'b0, 10'd0, 1'b0, 26'd0},
        '{R_CFG, jets_pkg::CFG_PAN_IM, 32'd0, 10'd0, 10'd0, 1'b0, 10'd0, 1'b0, 26'd0},
        '{R_CFG, jets_pkg::CFG_MAX_ITER, 32'd64, 10'd0, 10'd0, 1'b0, 10'd0, 1'b0, 26'd0},
        '{R_PIX, CFG_NONE_IDX, 32'd0, 10'd700, 10'd300, 1'b0, 10'd0, 1'b0, 26'd0}
    };

    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          i_in_valid   = 1'b0;
    logic                          o_in_stall;
    logic [jets_pkg::PIX_W-1:0]    i_pixel_x    = '0;
    logic [jets_pkg::PIX_W-1:0]    i_pixel_y    = '0;
    logic                          o_out_valid;
    logic                          i_out_stall  = 1'b0;
    logic [jets_pkg::ITER_W-1:0]   o_iter_count;
    logic                          o_escaped;
    logic [jets_pkg::SUM_W-1:0]    o_smooth_sum;
    logic                          i_cfg_valid  = 1'b0;
    logic                          o_cfg_ready;
    logic [jets_pkg::IDX_W-1:0]    i_cfg_index  = '0;
    logic [jets_pkg::Z_W-1:0]      i_cfg_data   = '0;

    jets_pkg::t_cfg      view_cfg;
    int unsigned         exp_rom [jets_pkg::EXP_TABLE_DEPTH];
    t_pixel_res          escape_q [$];
    int                  mismatches    = 0;
    int                  cycle_cnt     = 0;
    int                  in_idle_pct   = 6;
    int                  out_stall_pct = 52;

    julia_escape_time_smooth dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_iter_count (o_iter_count),
        .o_escaped    (o_escaped),
        .o_smooth_sum (o_smooth_sum),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // Clock with a period of 10.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Timeout guard.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    // One entry of the exponential table: Taylor series of e^-u in Q0.32, squared three times.
    function automatic int unsigned exp_sample(int unsigned i);
        t_u64   u;
        t_u64   term;
        t_u64   s;
        t_u64   k;
        longint acc;
        if (i == 0) begin
            return 65536;
        end
        u    = (t_u64'(i) << 32) / jets_pkg::EXP_TABLE_DEPTH;
        acc  = longint'(1) << 32;
        term = t_u64'(1) << 32;
        for (k = 1; k <= 12; k++) begin
            term = ((term * u) >> 32) / k;
            if (k[0]) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        s = t_u64'(acc);
        if (s > 64'hFFFF_FFFF) begin
            s = 64'hFFFF_FFFF;
        end
        for (k = 0; k < 3; k++) begin
            s = (s * s) >> 32;
        end
        return 32'((s + 64'd32768) >> 16);
    endfunction

    // Exponential weight of one magnitude; zero from 8 upward.
    function automatic int unsigned exp_weight(t_u64 m);
        t_u64 idx;
        if (m >= MAG_EXP_CUT) begin
            return 0;
        end
        idx = ((m >> 27) * jets_pkg::EXP_TABLE_DEPTH) >> 32;
        if (idx >= jets_pkg::EXP_TABLE_DEPTH) begin
            idx = jets_pkg::EXP_TABLE_DEPTH - 1;
        end
        return exp_rom[idx];
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic t_u64 mag_sq(longint zr, longint zi);
        return $unsigned(zr * zr) + $unsigned(zi * zi);
    endfunction

    // Escape-time iteration of one pixel under the current register settings.
    function automatic t_pixel_res julia_pixel(logic [jets_pkg::PIX_W-1:0] px,
                                               logic [jets_pkg::PIX_W-1:0] py);
        longint      zr;
        longint      zi;
        longint      nr;
        longint      ni;
        longint      c_re;
        longint      c_im;
        t_u64        m;
        int unsigned acc;
        int unsigned n;
        logic        esc;
        t_pixel_res  r;
        c_re = longint'($signed(view_cfg.const_re));
        c_im = longint'($signed(view_cfg.const_im));
        zr   = clamp32((longint'(px) - longint'(jets_pkg::IMG_WIDTH / 2))
                       * longint'(view_cfg.step_re)
                       + longint'($signed(view_cfg.pan_re)));
        zi   = clamp32((longint'(py) - longint'(jets_pkg::IMG_HEIGHT / 2))
                       * longint'(view_cfg.step_im)
                       + longint'($signed(view_cfg.pan_im)));
        acc  = exp_weight(mag_sq(zr, zi));
        n    = 0;
        esc  = 1'b0;
        while (n < view_cfg.max_iter && !esc) begin
            nr  = clamp32(((zr * zr - zi * zi) >>> 28) + c_re);
            ni  = clamp32(((zr * zi) >>> 27) + c_im);
            zr  = nr;
            zi  = ni;
            m   = mag_sq(zr, zi);
            acc = acc + exp_weight(m);
            if (acc > SUM_CAP) begin
                acc = SUM_CAP;
            end
            n++;
            if (m > MAG_ESC) begin
                esc = 1'b1;
            end
        end
        r.iters   = n[jets_pkg::ITER_W-1:0];
        r.escaped = esc;
        r.smooth  = acc[jets_pkg::SUM_W-1:0];
        return r;
    endfunction

    // Random signed value in [-half, half], as a 32-bit word.
    function automatic logic [jets_pkg::Z_W-1:0] rand_span(int unsigned half);
        logic [jets_pkg::Z_W-1:0] v;
        v = $urandom_range(0, 2 * half);
        return v - half;
    endfunction

    task automatic note_mismatch(string what, longint got, longint want);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_cnt, what, got, want);
        mismatches++;
    endtask

    task automatic drop_in_valid();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic drain_results();
        while (escape_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // One pixel request; valid stays high into the next call unless the sender idles.
    task automatic send_pixel(logic [jets_pkg::PIX_W-1:0] px, logic [jets_pkg::PIX_W-1:0] py,
                              logic typed, t_pixel_res typed_res);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel_x  <= px;
        i_pixel_y  <= py;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        if (typed) begin
            escape_q.push_back(typed_res);
        end else begin
            escape_q.push_back(julia_pixel(px, py));
        end
    endtask

    // Register write, made only once the engine has delivered every pending result.
    task automatic write_reg(logic [jets_pkg::IDX_W-1:0] idx, logic [jets_pkg::Z_W-1:0] data);
        drop_in_valid();
        drain_results();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        case (idx)
            jets_pkg::CFG_CONST_RE: view_cfg.const_re = data;
            jets_pkg::CFG_CONST_IM: view_cfg.const_im = data;
            jets_pkg::CFG_STEP_RE:  view_cfg.step_re  = data[jets_pkg::STEP_W-1:0];
            jets_pkg::CFG_STEP_IM:  view_cfg.step_im  = data[jets_pkg::STEP_W-1:0];
            jets_pkg::CFG_PAN_RE:   view_cfg.pan_re   = data;
            jets_pkg::CFG_PAN_IM:   view_cfg.pan_im   = data;
            jets_pkg::CFG_MAX_ITER: view_cfg.max_iter = data[jets_pkg::ITER_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Result checker: each accepted result against the oldest pending one.
    always @(posedge i_clk) begin
        t_pixel_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (escape_q.size() == 0) begin
                note_mismatch("unexpected result, iter_count", o_iter_count, -1);
            end else begin
                want = escape_q.pop_front();
                if (o_iter_count !== want.iters) begin
                    note_mismatch("iter_count", o_iter_count, want.iters);
                end
                if (o_escaped !== want.escaped) begin
                    note_mismatch("escaped", o_escaped, want.escaped);
                end
                if (o_smooth_sum !== want.smooth) begin
                    note_mismatch("smooth_sum", o_smooth_sum, want.smooth);
                end
            end
        end
    end

    // Stimulus: reset, directed table, then random phases.
    initial begin
        int                       i;
        int                       p;
        int                       k;
        int                       n_items;
        int unsigned              lim;
        logic [jets_pkg::Z_W-1:0] d;
        t_dir_row                 row;

        for (i = 0; i < jets_pkg::EXP_TABLE_DEPTH; i++) begin
            exp_rom[i] = exp_sample(i);
        end
        view_cfg = '{const_re: jets_pkg::RST_CONST_RE, const_im: jets_pkg::RST_CONST_IM,
                     step_re: jets_pkg::RST_STEP_RE, step_im: jets_pkg::RST_STEP_IM,
                     pan_re: jets_pkg::RST_PAN_RE, pan_im: jets_pkg::RST_PAN_IM,
                     max_iter: jets_pkg::RST_MAX_ITER};

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part.
        for (i = 0; i < DIR_ROWS; i++) begin
            row = DIR_TBL[i];
            if (row.kind == R_CFG) begin
                write_reg(row.idx, row.data);
            end else begin
                send_pixel(row.px, row.py, row.typed, '{row.iters, row.escaped, row.smooth});
            end
        end

        // Random phases: sender idles lightly first, then the receiver, then neither.
        for (p = 0; p < 12; p++) begin
            in_idle_pct   = (p < 4) ? 6 : (p < 8) ? 52 : 0;
            out_stall_pct = (p < 4) ? 52 : (p < 8) ? 6 : 0;

            write_reg(jets_pkg::CFG_CONST_RE, ($urandom_range(0, 3) == 0) ? $urandom
                                                  : rand_span(32'h2000_0000));
            write_reg(jets_pkg::CFG_CONST_IM, ($urandom_range(0, 3) == 0) ? $urandom
                                                  : rand_span(32'h2000_0000));
            for (k = 0; k < 2; k++) begin
                if (p == 9) begin
                    d = 32'hFFFF_FFFF;
                end else if (p == 10) begin
                    d = 32'h0;
                end else begin
                    d = {1'($urandom_range(0, 1)), 31'($urandom_range(0, 32'h0010_0000))};
                end
                write_reg((k == 0) ? jets_pkg::CFG_STEP_RE : jets_pkg::CFG_STEP_IM, d);
            end
            write_reg(jets_pkg::CFG_PAN_RE, ($urandom_range(0, 3) == 0) ? $urandom
                                                : rand_span(32'h1000_0000));
            write_reg(jets_pkg::CFG_PAN_IM, ($urandom_range(0, 3) == 0) ? $urandom
                                                : rand_span(32'h1000_0000));
            // Mostly short limits; a few phases at one, the default and the largest.
            lim = (p == 2) ? 1023 : (p == 5) ? 1 : (p == 7) ? 256 : $urandom_range(1, 48);
            d = $urandom;
            d[jets_pkg::ITER_W-1:0] = lim[jets_pkg::ITER_W-1:0];
            write_reg(jets_pkg::CFG_MAX_ITER, d);
            write_reg(CFG_NONE_IDX, $urandom);

            n_items = (p == 2) ? 6 : (p == 7) ? 40 : 110;
            for (k = 0; k < n_items; k++) begin
                send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                           1'b0, '0);
                // Once, hold the sender until the engine has emptied.
                if (p == 4 && k == 60) begin
                    drop_in_valid();
                    drain_results();
                end
            end
        end

        drop_in_valid();
        drain_results();
        repeat (2 * view_cfg.max_iter + 16) @(posedge i_clk);
        if (mismatches == 0 && escape_q.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/jets_pkg.sv
rtl/jets_cfg.sv
rtl/jets_dp.sv
rtl/jets_ctrl.sv
rtl/julia_escape_time_smooth.sv
test/tb.sv
